FILE: sv/rvde_pkg.sv
// shared types and constants for the rv32im decode/execute core
package rvde_pkg;

    // major opcodes
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MUL  = 7'h01;

    localparam logic [31:0] SIGN32 = 32'h8000_0000;
    localparam logic [31:0] ALL1   = 32'hFFFF_FFFF;

    // load kinds (funct3)
    localparam logic [2:0] LK_B  = 3'd0;
    localparam logic [2:0] LK_H  = 3'd1;
    localparam logic [2:0] LK_BU = 3'd4;
    localparam logic [2:0] LK_HU = 3'd5;

    // queued transaction from the front end
    typedef struct packed {
        logic        func;
        logic [31:0] instr;
        logic [31:0] load_data;
    } item_t;

    // result of one transaction
    typedef struct packed {
        logic [31:0] next_pc;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] mem_addr;
        logic [1:0]  mem_size;
        logic [31:0] mem_wdata;
        logic        halted;
        logic [31:0] halt_code;
        logic        illegal;
    } result_t;

endpackage

FILE: sv/rvde_fifo.sv
// small queue between the front end and the execute engine
module rvde_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rvde_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output rvde_pkg::item_t   out_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rvde_pkg::item_t mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == (AW+1)'(DEPTH) |-> !push) else $error("push into full queue");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count step");

endmodule

FILE: sv/rvde_divider.sv
// radix-2 restoring divider for unsigned 32-bit operands
module rvde_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] trial;

    assign trial     = {r_reg, q_reg[31]} - {1'b0, d_reg};
    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign done      = busy_reg && (cnt_reg == 6'd32);

    // one quotient bit a step
    always_comb
    begin
        if (trial[32])
        begin
            r_next = {r_reg[30:0], q_reg[31]};
            q_next = {q_reg[30:0], 1'b0};
        end
        else
        begin
            r_next = trial[31:0];
            q_next = {q_reg[30:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            q_reg    <= dividend;
            r_reg    <= '0;
            d_reg    <= divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd32)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                q_reg   <= q_next;
                r_reg   <= r_next;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 6'd32) else $error("divider step overrun");
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && !start |=> !busy_reg) else $error("divider stuck");
    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == 6'd0) else $error("divider start");

endmodule

FILE: sv/rvde_exec.sv
// execute engine: register file, pc, pending load, alu, multiply and divide
module rvde_exec (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_pc,
    input  logic                in_valid,
    output logic                in_ready,
    input  rvde_pkg::item_t     in_item,
    output logic                res_valid,
    input  logic                res_ready,
    output rvde_pkg::result_t   res
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_FIX, S_OUT} state_t;

    state_t              state_reg;
    rvde_pkg::item_t     it_reg;
    logic [31:0]         rf_mem [32];
    logic [31:0]         a_reg, b_reg, a0_reg;
    logic [31:0]         pc_reg;
    logic                pv_reg;
    logic [4:0]          pdest_reg;
    logic [2:0]          pkind_reg;
    rvde_pkg::result_t   res_reg;
    logic [63:0]         prod_reg;
    logic                div_start;
    logic                div_done;
    logic [31:0]         div_q, div_r;
    logic [31:0]         div_a, div_b;

    // decoded fields
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] immi, imms, immb, immj, immu;
    assign op   = it_reg.instr[6:0];
    assign f3   = it_reg.instr[14:12];
    assign f7   = it_reg.instr[31:25];
    assign rd   = it_reg.instr[11:7];
    assign immi = {{20{it_reg.instr[31]}}, it_reg.instr[31:20]};
    assign imms = {{20{it_reg.instr[31]}}, it_reg.instr[31:25], it_reg.instr[11:7]};
    assign immb = {{19{it_reg.instr[31]}}, it_reg.instr[31], it_reg.instr[7],
                   it_reg.instr[30:25], it_reg.instr[11:8], 1'b0};
    assign immj = {{11{it_reg.instr[31]}}, it_reg.instr[31], it_reg.instr[19:12],
                   it_reg.instr[20], it_reg.instr[30:21], 1'b0};
    assign immu = {it_reg.instr[31:12], 12'h000};

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

    // combinational execute decision
    logic              e_we;
    logic [31:0]       e_wd;
    logic              e_mul, e_div;
    rvde_pkg::result_t e_res;
    logic              e_ld;
    logic [31:0]       sum_ab, sum_ai, sub_ab, opb;
    logic              lt_s, lt_u, take;
    logic [31:0]       shamt_src;

    always_comb
    begin
        e_we  = 1'b0;
        e_wd  = '0;
        e_mul = 1'b0;
        e_div = 1'b0;
        e_ld  = 1'b0;
        take  = 1'b0;
        e_res = '0;
        e_res.next_pc = pc_reg + 32'd4;
        opb       = (op == rvde_pkg::OP_REG) ? b_reg : immi;
        sum_ab    = a_reg + opb;
        sum_ai    = a_reg + immi;
        sub_ab    = a_reg - b_reg;
        lt_s      = (a_reg ^ rvde_pkg::SIGN32) < (opb ^ rvde_pkg::SIGN32);
        lt_u      = a_reg < opb;
        shamt_src = opb;
        case (op)
            rvde_pkg::OP_LUI:
            begin
                e_we = 1'b1; e_wd = immu;
            end
            rvde_pkg::OP_AUIPC:
            begin
                e_we = 1'b1; e_wd = pc_reg + immu;
            end
            rvde_pkg::OP_JAL:
            begin
                e_we = 1'b1; e_wd = pc_reg + 32'd4;
                e_res.next_pc = pc_reg + immj;
            end
            rvde_pkg::OP_JALR:
            begin
                if (f3 != 3'd0)
                begin
                    e_res.illegal = 1'b1;
                end
                else
                begin
                    e_we = 1'b1; e_wd = pc_reg + 32'd4;
                    e_res.next_pc = sum_ai & ~32'd1;
                end
            end
            rvde_pkg::OP_BRANCH:
            begin
                case (f3)
                    3'd0: take = (a_reg == b_reg);
                    3'd1: take = (a_reg != b_reg);
                    3'd4: take = (a_reg ^ rvde_pkg::SIGN32) < (b_reg ^ rvde_pkg::SIGN32);
                    3'd5: take = !((a_reg ^ rvde_pkg::SIGN32) < (b_reg ^ rvde_pkg::SIGN32));
                    3'd6: take = a_reg < b_reg;
                    3'd7: take = a_reg >= b_reg;
                    default: e_res.illegal = 1'b1;
                endcase
                if (take)
                begin
                    e_res.next_pc = pc_reg + immb;
                end
            end
            rvde_pkg::OP_LOAD:
            begin
                if (f3 == 3'd3 || f3 > 3'd5)
                begin
                    e_res.illegal = 1'b1;
                end
                else
                begin
                    e_ld = 1'b1;
                    e_res.mem_read = 1'b1;
                    e_res.mem_addr = sum_ai;
                    e_res.mem_size = f3[1:0];
                end
            end
            rvde_pkg::OP_STORE:
            begin
                if (f3 > 3'd2)
                begin
                    e_res.illegal = 1'b1;
                end
                else
                begin
                    e_res.mem_write = 1'b1;
                    e_res.mem_addr  = a_reg + imms;
                    e_res.mem_size  = f3[1:0];
                    e_res.mem_wdata = b_reg;
                end
            end
            rvde_pkg::OP_IMM, rvde_pkg::OP_REG:
            begin
                e_we = 1'b1;
                if (op == rvde_pkg::OP_REG && f7 == rvde_pkg::F7_MUL)
                begin
                    e_we  = 1'b0;
                    e_mul = !f3[2];
                    e_div = f3[2];
                end
                else if (op == rvde_pkg::OP_REG && f7 != rvde_pkg::F7_BASE
                         && !(f7 == rvde_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5)))
                begin
                    e_we = 1'b0; e_res.illegal = 1'b1;
                end
                else
                begin
                    case (f3)
                        3'd0: e_wd = (op == rvde_pkg::OP_REG && f7 == rvde_pkg::F7_ALT)
                                     ? sub_ab : sum_ab;
                        3'd1:
                        begin
                            if (op == rvde_pkg::OP_IMM && f7 != rvde_pkg::F7_BASE)
                            begin
                                e_we = 1'b0; e_res.illegal = 1'b1;
                            end
                            e_wd = a_reg << shamt_src[4:0];
                        end
                        3'd2: e_wd = {31'd0, lt_s};
                        3'd3: e_wd = {31'd0, lt_u};
                        3'd4: e_wd = a_reg ^ opb;
                        3'd5:
                        begin
                            if (f7 == rvde_pkg::F7_BASE)
                            begin
                                e_wd = a_reg >> shamt_src[4:0];
                            end
                            else if (f7 == rvde_pkg::F7_ALT)
                            begin
                                e_wd = 32'($signed(a_reg) >>> shamt_src[4:0]);
                            end
                            else
                            begin
                                e_we = 1'b0; e_res.illegal = 1'b1;
                            end
                        end
                        3'd6: e_wd = a_reg | opb;
                        default: e_wd = a_reg & opb;
                    endcase
                end
            end
            default:
            begin
                if (it_reg.instr == rvde_pkg::INSN_EBREAK)
                begin
                    e_res.halted    = 1'b1;
                    e_res.halt_code = a0_reg;
                end
                else
                begin
                    e_res.illegal = 1'b1;
                end
            end
        endcase
    end

    // multiply and divide finishing
    logic [31:0] mul_res, div_res;
    logic        sa, sb;
    assign sa = a_reg[31];
    assign sb = b_reg[31];
    always_comb
    begin
        case (f3[1:0])
            2'd0: mul_res = prod_reg[31:0];
            2'd1: mul_res = prod_reg[63:32] - (sa ? b_reg : 32'd0) - (sb ? a_reg : 32'd0);
            2'd2: mul_res = prod_reg[63:32] - (sa ? b_reg : 32'd0);
            default: mul_res = prod_reg[63:32];
        endcase
        case (f3[1:0])
            2'd0:
            begin
                if (b_reg == 32'd0) div_res = rvde_pkg::ALL1;
                else if (a_reg == rvde_pkg::SIGN32 && b_reg == rvde_pkg::ALL1)
                    div_res = rvde_pkg::SIGN32;
                else div_res = (sa ^ sb) ? 32'd0 - div_q : div_q;
            end
            2'd1: div_res = (b_reg == 32'd0) ? rvde_pkg::ALL1 : div_q;
            2'd2:
            begin
                if (b_reg == 32'd0) div_res = a_reg;
                else if (a_reg == rvde_pkg::SIGN32 && b_reg == rvde_pkg::ALL1)
                    div_res = 32'd0;
                else div_res = sa ? 32'd0 - div_r : div_r;
            end
            default: div_res = (b_reg == 32'd0) ? a_reg : div_r;
        endcase
    end

    // load reply extension
    logic [31:0] ld_ext;
    always_comb
    begin
        case (pkind_reg)
            rvde_pkg::LK_B:  ld_ext = {{24{it_reg.load_data[7]}}, it_reg.load_data[7:0]};
            rvde_pkg::LK_H:  ld_ext = {{16{it_reg.load_data[15]}}, it_reg.load_data[15:0]};
            rvde_pkg::LK_BU: ld_ext = {24'd0, it_reg.load_data[7:0]};
            rvde_pkg::LK_HU: ld_ext = {16'd0, it_reg.load_data[15:0]};
            default:         ld_ext = it_reg.load_data;
        endcase
    end

    // divider operands as magnitudes, taken by the divider at start
    logic signed_div;
    assign signed_div = !f3[0];
    assign div_a      = (signed_div && sa) ? 32'd0 - a_reg : a_reg;
    assign div_b      = (signed_div && sb) ? 32'd0 - b_reg : b_reg;
    assign div_start  = (state_reg == S_EXEC) && e_div && !e_res.illegal;

    rvde_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // register file
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;
    always_comb
    begin
        rf_we = 1'b0;
        rf_wa = rd;
        rf_wd = e_wd;
        case (state_reg)
            S_READ:
            begin
                rf_we = it_reg.func && pv_reg;
                rf_wa = pdest_reg;
                rf_wd = ld_ext;
            end
            S_EXEC: rf_we = e_we && !e_res.illegal;
            S_MUL:  begin rf_we = 1'b1; rf_wd = mul_res; end
            S_FIX:  begin rf_we = 1'b1; rf_wd = div_res; end
            default: rf_we = 1'b0;
        endcase
    end

    // register file, operand read for the transaction held in it_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_mem   <= '{default: '0};
            a_reg    <= '0;
            b_reg    <= '0;
            a0_reg   <= '0;
            prod_reg <= '0;
        end
        else
        begin
            if (rf_we && rf_wa != 5'd0)
            begin
                rf_mem[rf_wa] <= rf_wd;
            end
            if (state_reg == S_READ)
            begin
                a_reg  <= rf_mem[it_reg.instr[19:15]];
                b_reg  <= rf_mem[it_reg.instr[24:20]];
                a0_reg <= rf_mem[5'd10];
            end
            if (state_reg == S_EXEC)
            begin
                prod_reg <= a_reg * b_reg;
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= rvde_pkg::SIGN32;
            pv_reg    <= 1'b0;
            pdest_reg <= '0;
            pkind_reg <= '0;
            it_reg    <= '0;
            res_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                pc_reg <= cfg_pc;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        it_reg    <= in_item;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (it_reg.func)
                    begin
                        pv_reg    <= 1'b0;
                        res_reg   <= '{next_pc: pc_reg, default: '0};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_reg <= e_res;
                    pc_reg  <= e_res.next_pc;
                    if (e_ld && !e_res.illegal)
                    begin
                        pv_reg    <= 1'b1;
                        pdest_reg <= rd;
                        pkind_reg <= f3;
                    end
                    if (e_mul)      state_reg <= S_MUL;
                    else if (e_div) state_reg <= S_DIV;
                    else            state_reg <= S_OUT;
                end
                S_MUL: state_reg <= S_OUT;
                S_DIV: if (div_done) state_reg <= S_FIX;
                S_FIX: state_reg <= S_OUT;
                S_OUT: if (res_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_mem: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.mem_read && res.mem_write)) else $error("read and write");
    a_ill_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.illegal |-> !res.mem_read && !res.mem_write && !res.halted)
        else $error("illegal with side effect");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res)) else $error("result changed");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> state_reg == S_DIV) else $error("divide sequencing");

endmodule

FILE: sv/rv32im_decode_execute_core.sv
// top level of the rv32im decode/execute core
//
// Usage: each input transaction is an instruction word (func = 0) or the
// reply data of a pending load (func = 1), on a valid/ready channel. Each
// transaction gives exactly one result transaction: the next pc and any
// memory request, halt or illegal flag, on a second valid/ready channel.
// The front queue (two entries) takes transactions while the execute engine
// is busy. The engine runs one transaction at a time: queue read, register
// file read, execute and result for most instructions; load replies skip
// the execute step, mul/mulh/mulhsu/mulhu add a step after the one registered
// multiply, and div/divu/rem/remu wait for the one-bit-per-cycle divider.
// The result register holds its transaction while the receiver stalls; the
// engine then waits and the queue fills before in ready drops.
// Reset clears the register file to zero, loads the pc with 0x80000000 and
// clears the pending load. A write of start_pc over the APB port also loads
// the pc.
module rv32im_decode_execute_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [31:0] instr,
    input  logic [31:0] load_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] next_pc,
    output logic        mem_read,
    output logic        mem_write,
    output logic [31:0] mem_addr,
    output logic [1:0]  mem_size,
    output logic [31:0] mem_wdata,
    output logic        halted,
    output logic [31:0] halt_code,
    output logic        illegal
);
    rvde_pkg::item_t   in_item, q_item;
    rvde_pkg::result_t res;
    logic              q_valid, q_ready;
    logic              cfg_we;
    logic [31:0]       start_pc_reg;

    assign in_item = '{func: func, instr: instr, load_data: load_data};

    // configuration register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? start_pc_reg : 32'd0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg <= rvde_pkg::SIGN32;
        end
        else if (cfg_we)
        begin
            start_pc_reg <= pwdata;
        end
    end

    rvde_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    rvde_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_pc    (pwdata),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign next_pc   = res.next_pc;
    assign mem_read  = res.mem_read;
    assign mem_write = res.mem_write;
    assign mem_addr  = res.mem_addr;
    assign mem_size  = res.mem_size;
    assign mem_wdata = res.mem_wdata;
    assign halted    = res.halted;
    assign halt_code = res.halt_code;
    assign illegal   = res.illegal;

    a_cfg_pc: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> start_pc_reg == $past(pwdata)) else $error("start_pc write");
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(halted && illegal)) else $error("halt and illegal");
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready) else $error("pready low");

endmodule
